// ----- rtl/sbct_pkg.sv -----
// Package for the sphere/box contact test: request and result types, codes and constants.
package sbct_pkg;

	// Fraction bits of the fixed-point format
	localparam int FRAC_BITS = 16;

	// Configuration register indexes
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	// Face direction codes
	localparam logic [2:0] DIR_POS_X = 3'd0;
	localparam logic [2:0] DIR_NEG_X = 3'd1;
	localparam logic [2:0] DIR_POS_Z = 3'd2;
	localparam logic [2:0] DIR_NEG_Z = 3'd3;
	localparam logic [2:0] DIR_NONE  = 3'd4;

	// Penetration limits and the miss value (-1000.0, saturated)
	localparam logic signed [31:0] PEN_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] PEN_MIN = 32'sh8000_0000;
	localparam logic signed [63:0] MISS_RAW = -(64'sd1000 <<< FRAC_BITS);
	localparam logic signed [31:0] MISS_PEN =
		(MISS_RAW < -64'sd2147483648) ? PEN_MIN : MISS_RAW[31:0];

	// Square root: 66-bit radicand, one root bit per stage
	localparam int SQ_STEPS = 33;
	localparam int SQ_RAD_W = 2 * SQ_STEPS;
	localparam int SQ_REM_W = SQ_STEPS + 3;

	typedef struct packed {
		logic signed [31:0] sphere_x;
		logic signed [31:0] sphere_y;
		logic signed [31:0] sphere_z;
		logic [30:0]        sphere_radius;
	} sbct_req_t;

	typedef struct packed {
		logic               hit;
		logic [2:0]         face_dir;
		logic signed [31:0] penetration;
	} sbct_res_t;

endpackage

// ----- rtl/sphere_box_contact_test_unit.sv -----
// Sphere against axis-aligned box contact test, fully pipelined with a bit-per-stage square root.
//
//  channel   signals                              handshake
//  request   start, busy, req                     taken when start & !busy
//  result    done, result                         one cycle strobe, no back-pressure
//  config    cfg_we, cfg_index, cfg_data          written when cfg_we is high
//
// One request per clock; busy is never raised. Each result passes through four
// arithmetic stages, 33 square-root stages (one root bit each) and the output
// register. The root pipeline sets the latency.
// Reset clears the box registers to zero and every valid bit in the pipeline.
// The receiver cannot stall, so the pipeline advances on every clock.
module sphere_box_contact_test_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sbct_pkg::sbct_req_t  req,
	output logic                 done,
	output sbct_pkg::sbct_res_t  result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int N  = sbct_pkg::SQ_STEPS;
	localparam int RW = sbct_pkg::SQ_REM_W;
	localparam int DW = sbct_pkg::SQ_RAD_W;

	// Box registers
	logic signed [31:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0; min_y_q <= '0; min_z_q <= '0;
			max_x_q <= '0; max_y_q <= '0; max_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbct_pkg::REG_MIN_X: min_x_q <= cfg_data;
				sbct_pkg::REG_MIN_Y: min_y_q <= cfg_data;
				sbct_pkg::REG_MIN_Z: min_z_q <= cfg_data;
				sbct_pkg::REG_MAX_X: max_x_q <= cfg_data;
				sbct_pkg::REG_MAX_Y: max_y_q <= cfg_data;
				sbct_pkg::REG_MAX_Z: max_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// Stage 1: overlap test, doubled offsets and doubled extents
	function automatic logic ax_hit(input logic signed [31:0] c, input logic [30:0] r,
		input logic signed [31:0] mn, input logic signed [31:0] mx);
		logic signed [32:0] c33, r33, lo, hi;
		c33 = {c[31], c};
		r33 = {2'b00, r};
		lo  = c33 + r33;
		hi  = c33 - r33;
		return (lo > $signed({mn[31], mn})) && (hi < $signed({mx[31], mx}));
	endfunction

	function automatic logic signed [34:0] ax_off(input logic signed [31:0] c,
		input logic signed [31:0] mn, input logic signed [31:0] mx);
		logic signed [34:0] c2, s;
		c2 = {{2{c[31]}}, c, 1'b0};
		s  = $signed({{3{mn[31]}}, mn}) + $signed({{3{mx[31]}}, mx});
		return c2 - s;
	endfunction

	function automatic logic signed [33:0] ax_ext(input logic signed [31:0] mn,
		input logic signed [31:0] mx);
		return $signed({{2{mx[31]}}, mx}) - $signed({{2{mn[31]}}, mn});
	endfunction

	logic               vld_s1, hit_s1;
	logic [30:0]        rad_s1;
	logic signed [34:0] dx_s1, dy_s1, dz_s1;
	logic signed [33:0] hx_s1, hy_s1, hz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		hit_s1 <= ax_hit(req.sphere_x, req.sphere_radius, min_x_q, max_x_q)
			&& ax_hit(req.sphere_y, req.sphere_radius, min_y_q, max_y_q)
			&& ax_hit(req.sphere_z, req.sphere_radius, min_z_q, max_z_q);
		rad_s1 <= req.sphere_radius;
		dx_s1  <= ax_off(req.sphere_x, min_x_q, max_x_q);
		dy_s1  <= ax_off(req.sphere_y, min_y_q, max_y_q);
		dz_s1  <= ax_off(req.sphere_z, min_z_q, max_z_q);
		hx_s1  <= ax_ext(min_x_q, max_x_q);
		hy_s1  <= ax_ext(min_y_q, max_y_q);
		hz_s1  <= ax_ext(min_z_q, max_z_q);
	end

	// Stage 2: clamp to the box, magnitude of the doubled vector, face choice
	// On a hit each component stays below 2^32, so 32 bits of magnitude suffice.
	function automatic logic [31:0] ax_vec(input logic signed [34:0] d,
		input logic signed [33:0] h);
		logic signed [34:0] hp, hn, k, v, m;
		hp = {h[33], h};
		hn = -hp;
		k  = (d < hn) ? hn : d;
		k  = (k > hp) ? hp : k;
		v  = k - d;
		m  = v[34] ? -v : v;
		return m[31:0];
	endfunction

	logic        vld_s2, hit_s2;
	logic [30:0] rad_s2;
	logic [2:0]  dir_s2;
	logic [31:0] vx_s2, vy_s2, vz_s2;
	logic [34:0] adx, adz;

	assign adx = dx_s1[34] ? 35'(-dx_s1) : 35'(dx_s1);
	assign adz = dz_s1[34] ? 35'(-dz_s1) : 35'(dz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		hit_s2 <= hit_s1;
		rad_s2 <= rad_s1;
		vx_s2  <= ax_vec(dx_s1, hx_s1);
		vy_s2  <= ax_vec(dy_s1, hy_s1);
		vz_s2  <= ax_vec(dz_s1, hz_s1);
		// first candidate wins ties
		if (adz > adx) dir_s2 <= dz_s1[34] ? sbct_pkg::DIR_NEG_Z : sbct_pkg::DIR_POS_Z;
		else           dir_s2 <= dx_s1[34] ? sbct_pkg::DIR_NEG_X : sbct_pkg::DIR_POS_X;
	end

	// Stage 3: squares
	logic        vld_s3, hit_s3;
	logic [30:0] rad_s3;
	logic [2:0]  dir_s3;
	logic [63:0] qx_s3, qy_s3, qz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		hit_s3 <= hit_s2;
		rad_s3 <= rad_s2;
		dir_s3 <= dir_s2;
		qx_s3  <= vx_s2 * vx_s2;
		qy_s3  <= vy_s2 * vy_s2;
		qz_s3  <= vz_s2 * vz_s2;
	end

	// Stage 4: sum of squares, seeds the root pipeline
	logic          sq_vld_s [0:N];
	logic          sq_hit_s [0:N];
	logic [30:0]   sq_r_s   [0:N];
	logic [2:0]    sq_dir_s [0:N];
	logic [DW-1:0] sq_rad_s [0:N];
	logic [RW-1:0] sq_rem_s [0:N];
	logic [N-1:0]  sq_root_s[0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld_s[0] <= 1'b0;
		else         sq_vld_s[0] <= vld_s3;
	end

	always_ff @(posedge clk) begin
		sq_hit_s[0]  <= hit_s3;
		sq_r_s[0]    <= rad_s3;
		sq_dir_s[0]  <= dir_s3;
		sq_rad_s[0]  <= DW'(qx_s3) + DW'(qy_s3) + DW'(qz_s3);
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
	end

	// Root stages: bring down two radicand bits, try the next root bit
	for (genvar g = 0; g < N; g++) begin : g_sqrt
		logic [RW-1:0] rem_sh, trial;
		logic          take;

		assign rem_sh = {sq_rem_s[g][RW-3:0], sq_rad_s[g][DW-1 -: 2]};
		assign trial  = RW'({sq_root_s[g], 2'b01});
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[g+1] <= 1'b0;
			else         sq_vld_s[g+1] <= sq_vld_s[g];
		end

		always_ff @(posedge clk) begin
			sq_hit_s[g+1]  <= sq_hit_s[g];
			sq_r_s[g+1]    <= sq_r_s[g];
			sq_dir_s[g+1]  <= sq_dir_s[g];
			sq_rad_s[g+1]  <= {sq_rad_s[g][DW-3:0], 2'b00};
			sq_rem_s[g+1]  <= take ? (rem_sh - trial) : rem_sh;
			sq_root_s[g+1] <= {sq_root_s[g][N-2:0], take};
		end
	end

	// Output: radius minus half the root, saturated; miss value otherwise
	logic signed [33:0] pen_diff;
	logic signed [31:0] pen_sat;

	assign pen_diff = $signed({3'b000, sq_r_s[N]}) - $signed({2'b00, sq_root_s[N][N-1:1]});
	assign pen_sat  = (pen_diff[33:31] == {3{pen_diff[31]}}) ? pen_diff[31:0]
		: (pen_diff[33] ? sbct_pkg::PEN_MIN : sbct_pkg::PEN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= sq_vld_s[N];
	end

	always_ff @(posedge clk) begin
		result.hit         <= sq_hit_s[N];
		result.face_dir    <= sq_hit_s[N] ? sq_dir_s[N] : sbct_pkg::DIR_NONE;
		result.penetration <= sq_hit_s[N] ? pen_sat : sbct_pkg::MISS_PEN;
	end

	// A miss reports no face and the fixed miss penetration
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |->
			(result.face_dir == sbct_pkg::DIR_NONE && result.penetration == sbct_pkg::MISS_PEN))
		else $error("miss result carries a face or penetration");

	// A hit always names a face
	a_hit_face: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (result.face_dir != sbct_pkg::DIR_NONE))
		else $error("hit result without a face");

	// Every request leaves the pipeline after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##38 done)
		else $error("request lost in the pipeline");

endmodule

// ----- verif/sphere_box_contact_test_unit_test.sv -----
// Self-checking testbench for the sphere/box contact test unit.
module sphere_box_contact_test_unit_test;
	import sbct_pkg::*;

	localparam int LATENCY = 38;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sbct_req_t req = '0;
	logic done;
	sbct_res_t result;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_MIN_X;
	logic [31:0] cfg_data = '0;

	sphere_box_contact_test_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Box as seen by the predictor
	logic signed [31:0] box_lo [3];
	logic signed [31:0] box_hi [3];

	sbct_res_t pending_contacts [$];
	int fail_count = 0;
	int cycle_count = 0;
	bit calm_stretch = 1'b0;

	// Directed requests; the expected result is typed in where check_row is set
	typedef struct {
		sbct_req_t  rq;
		bit         check_row;
		sbct_res_t  want;
	} contact_row_t;

	always #5 clk = ~clk;

	// Stop on a runaway run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sphere_box_contact_test_unit verification failed");
			$finish;
		end
	end

	// Floor square root of a value below 2^70
	function automatic logic [39:0] floor_root(input logic [71:0] v);
		logic [71:0] rem;
		logic [39:0] root;
		logic [73:0] trial;
		rem = v;
		root = '0;
		for (int b = 36; b >= 0; b--) begin
			trial = ({34'd0, root} << (b + 1)) + (74'd1 << (2 * b));
			if (trial <= {2'b00, rem}) begin
				rem = rem - trial[71:0];
				root = root | (40'd1 << b);
			end
		end
		return root;
	endfunction

	// Doubled centre offset and doubled vector to the nearest box point on one axis
	function automatic void axis_gap(input logic signed [31:0] c, input int ax,
			output logic signed [35:0] off, output logic signed [35:0] gap);
		logic signed [35:0] h, k;
		off = 36'(2 * 36'(c)) - (36'(box_lo[ax]) + 36'(box_hi[ax]));
		h = 36'(box_hi[ax]) - 36'(box_lo[ax]);
		k = off;
		if (k < -h) k = -h;
		if (k > h) k = h;
		gap = k - off;
	endfunction

	function automatic sbct_res_t predict_contact(input sbct_req_t q);
		sbct_res_t r;
		logic signed [35:0] c [3];
		logic signed [35:0] rad, off [3], gap [3], pen, best;
		logic [71:0] sumsq;
		logic [35:0] mag;
		bit overlap;
		c[0] = 36'(q.sphere_x);
		c[1] = 36'(q.sphere_y);
		c[2] = 36'(q.sphere_z);
		rad = 36'({1'b0, q.sphere_radius});
		overlap = 1'b1;
		for (int a = 0; a < 3; a++)
			if (!(c[a] + rad > 36'(box_lo[a]) && c[a] - rad < 36'(box_hi[a])))
				overlap = 1'b0;
		r.hit = overlap;
		if (!overlap) begin
			r.face_dir = DIR_NONE;
			r.penetration = MISS_PEN;
			return r;
		end
		sumsq = '0;
		for (int a = 0; a < 3; a++) begin
			axis_gap(c[a][31:0], a, off[a], gap[a]);
			mag = gap[a] < 0 ? 36'(-gap[a]) : 36'(gap[a]);
			sumsq = sumsq + 72'(mag) * 72'(mag);
		end
		pen = rad - 36'(floor_root(sumsq) >> 1);
		if (pen > 36'(PEN_MAX)) r.penetration = PEN_MAX;
		else if (pen < 36'(PEN_MIN)) r.penetration = PEN_MIN;
		else r.penetration = pen[31:0];
		// First candidate wins ties
		r.face_dir = DIR_POS_X;
		best = off[0];
		if (-off[0] > best) begin best = -off[0]; r.face_dir = DIR_NEG_X; end
		if (off[2] > best) begin best = off[2]; r.face_dir = DIR_POS_Z; end
		if (-off[2] > best) begin best = -off[2]; r.face_dir = DIR_NEG_Z; end
		return r;
	endfunction

	// Compare each result strobe with the oldest expectation
	always @(posedge clk) begin
		sbct_res_t w;
		if (arst_n && done) begin
			if (pending_contacts.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				fail_count++;
			end else begin
				w = pending_contacts.pop_front();
				if (result.hit !== w.hit) begin
					$display("%0t: hit expected %b actual %b", $time, w.hit, result.hit);
					fail_count++;
				end
				if (result.face_dir !== w.face_dir) begin
					$display("%0t: face_dir expected %0d actual %0d", $time,
						w.face_dir, result.face_dir);
					fail_count++;
				end
				if (result.penetration !== w.penetration) begin
					$display("%0t: penetration expected %h actual %h", $time,
						w.penetration, result.penetration);
					fail_count++;
				end
			end
		end
	end

	task automatic write_box(input logic [2:0] idx, input logic signed [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx < REG_MAX_X) box_lo[idx] = v;
		else box_hi[idx - REG_MAX_X] = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_box(input logic signed [31:0] lo [3], input logic signed [31:0] hi [3]);
		write_box(REG_MIN_X, lo[0]);
		write_box(REG_MIN_Y, lo[1]);
		write_box(REG_MIN_Z, lo[2]);
		write_box(REG_MAX_X, hi[0]);
		write_box(REG_MAX_Y, hi[1]);
		write_box(REG_MAX_Z, hi[2]);
	endtask

	// Wait out the pipeline before touching the box
	task automatic drain;
		while (pending_contacts.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Offer one request at the falling edge, hold until taken
	task automatic send_request(input sbct_req_t q, input bit check_row, input sbct_res_t want);
		sbct_res_t p;
		if (!calm_stretch)
			while ($urandom_range(99) < 27) begin
				start <= 1'b0;
				@(negedge clk);
			end
		start <= 1'b1;
		req <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = predict_contact(q);
		if (check_row && p !== want) begin
			$display("%0t: table row expected %h predicted %h", $time, want, p);
			fail_count++;
		end
		pending_contacts.push_back(check_row ? want : p);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord(input int spread);
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom;
			default: return $signed($urandom_range(2 * spread)) - spread;
		endcase
	endfunction

	task automatic random_phase(input int count, input int spread);
		sbct_req_t q;
		for (int i = 0; i < count; i++) begin
			calm_stretch = (i >= count / 3 && i < count / 2);
			q.sphere_x = rand_coord(spread);
			q.sphere_y = rand_coord(spread);
			q.sphere_z = rand_coord(spread);
			case ($urandom_range(7))
				0: q.sphere_radius = 31'h7FFF_FFFF;
				1: q.sphere_radius = 31'($urandom);
				default: q.sphere_radius = 31'($urandom_range(2 * spread));
			endcase
			send_request(q, 1'b0, '0);
		end
		start <= 1'b0;
		calm_stretch = 1'b0;
	endtask

	initial begin
		contact_row_t rows [$];
		sbct_res_t miss;
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		miss = '{hit: 1'b0, face_dir: DIR_NONE, penetration: MISS_PEN};
		for (int a = 0; a < 3; a++) begin box_lo[a] = '0; box_hi[a] = '0; end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero box after reset: a unit sphere at the origin touches it
		rows.push_back('{'{32'sd0, 32'sd0, 32'sd0, 31'h1_0000}, 1'b1,
			'{1'b1, DIR_POS_X, 32'sh1_0000}});
		rows.push_back('{'{32'sd0, 32'sd0, 32'sd0, 31'd0}, 1'b1, miss});
		rows.push_back('{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF},
			1'b0, '0});
		rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF},
			1'b0, '0});
		rows.push_back('{'{32'sh8000_0000, 32'sd0, 32'sd0, 31'h7FFF_FFFF}, 1'b0, '0});
		rows.push_back('{'{32'sh7FFF_FFFF, 32'sd0, 32'sd0, 31'd5}, 1'b1, miss});
		foreach (rows[i]) send_request(rows[i].rq, rows[i].check_row, rows[i].want);
		start <= 1'b0;
		drain();

		// Unit box [-1,1]^3: inside, each face direction, touching edge, corner
		lo = '{-32'sh1_0000, -32'sh1_0000, -32'sh1_0000};
		hi = '{32'sh1_0000, 32'sh1_0000, 32'sh1_0000};
		set_box(lo, hi);
		rows.delete();
		rows.push_back('{'{32'sd0, 32'sd0, 32'sd0, 31'h1_0000}, 1'b1,
			'{1'b1, DIR_POS_X, 32'sh1_0000}});
		rows.push_back('{'{-32'sh8000, 32'sd0, 32'sd0, 31'h1_0000}, 1'b0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, 32'sh8000, 31'h1_0000}, 1'b0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, -32'sh8000, 31'h1_0000}, 1'b0, '0});
		rows.push_back('{'{32'sh2_0000, 32'sd0, 32'sd0, 31'h1_0000}, 1'b1, miss});
		rows.push_back('{'{32'sh1_8000, 32'sd0, 32'sd0, 31'h1_0000}, 1'b1,
			'{1'b1, DIR_POS_X, 32'sh8000}});
		rows.push_back('{'{32'sh1_8000, 32'sh1_8000, 32'sh1_8000, 31'h1_0000}, 1'b0, '0});
		rows.push_back('{'{32'sh8000, 32'sd0, 32'sh8000, 31'h7FFF_FFFF}, 1'b0, '0});
		foreach (rows[i]) send_request(rows[i].rq, rows[i].check_row, rows[i].want);
		start <= 1'b0;
		random_phase(RANDOM_ITEMS / 4, 32'h4_0000);
		drain();

		// Full-range box: every centre lies in the box, so a hit reports the radius as penetration
		lo = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		hi = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		set_box(lo, hi);
		random_phase(RANDOM_ITEMS / 4, 32'h4000_0000);
		drain();

		// Inverted box on x and y
		lo = '{32'sh3_0000, 32'sh1_0000, -32'sh2_0000};
		hi = '{-32'sh3_0000, -32'sh1_0000, 32'sh5_0000};
		set_box(lo, hi);
		random_phase(RANDOM_ITEMS / 4, 32'h8_0000);
		drain();

		// Random boxes of moderate size
		for (int p = 0; p < 4; p++) begin
			for (int a = 0; a < 3; a++) begin
				lo[a] = $signed($urandom_range(32'h10_0000)) - 32'sh8_0000;
				hi[a] = lo[a] + $signed($urandom_range(32'h8_0000));
			end
			set_box(lo, hi);
			random_phase(RANDOM_ITEMS / 16, 32'h10_0000);
			drain();
		end

		if (fail_count == 0) begin
			$display("sphere_box_contact_test_unit verification clean");
		end else begin
			$display("sphere_box_contact_test_unit verification failed");
		end
		$finish;
	end

endmodule
